### rtl/core/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam logic [7:0] FIN_BIT     = 8'h80;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [7:0] OPCODE_MASK = 8'h0F;
    localparam logic [7:0] LEN7_MASK   = 8'h7F;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_of_frame;
        logic [3:0] frame_opcode;
        logic       final_fragment;
    } t_result;

endpackage

### rtl/core/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Header parse, mask key capture and payload unmasking, one byte per cycle while i_accept is high.
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    output logic            o_res_valid,
    output wsd_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_idx,    n_idx;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin,    n_fin;
    logic        r_masked, n_masked;
    logic [63:0] r_remain, n_remain;   // payload bytes still to come
    logic [31:0] r_key,    n_key;
    logic [1:0]  r_kidx,   n_kidx;     // payload index mod 4

    logic [63:0] w_len;
    logic [3:0]  w_idx_inc;
    logic [7:0]  w_key_byte;

    assign w_idx_inc = r_idx + 4'd1;

    always_comb begin
        case (r_kidx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_masked = r_masked;
        n_remain = r_remain;
        n_key    = r_key;
        n_kidx   = r_kidx;
        w_len    = {r_remain[55:0], i_byte};

        o_res_valid          = 1'b0;
        o_res.payload_byte   = i_byte ^ w_key_byte;
        o_res.last_of_frame  = (r_remain == 64'd1);
        o_res.frame_opcode   = r_opcode;
        o_res.final_fragment = r_fin;

        if (i_accept) begin
            case (r_phase)
                PH_HDR1: begin
                    n_masked = |(i_byte & wsd_pkg::MASK_BIT);
                    n_idx    = 4'd0;
                    n_kidx   = 2'd0;
                    n_remain = {57'd0, i_byte[6:0]};
                    if (i_byte[6:0] == wsd_pkg::LEN_EXT16) begin
                        n_remain = 64'd0;
                        n_phase  = PH_EXT16;
                    end else if (i_byte[6:0] == wsd_pkg::LEN_EXT64) begin
                        n_remain = 64'd0;
                        n_phase  = PH_EXT64;
                    end else if (n_masked) begin
                        n_phase = PH_MASK;
                    end else if (i_byte[6:0] == 7'd0) begin
                        n_phase = PH_HDR0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    n_remain = w_len;
                    n_idx    = w_idx_inc;
                    if (w_idx_inc >= ((r_phase == PH_EXT16) ? wsd_pkg::EXT16_BYTES
                                                          : wsd_pkg::EXT64_BYTES)) begin
                        n_idx = 4'd0;
                        if (r_masked) begin
                            n_phase = PH_MASK;
                        end else if (w_len == 64'd0) begin
                            n_phase = PH_HDR0;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    n_idx = w_idx_inc;
                    if (w_idx_inc >= wsd_pkg::KEY_BYTES) begin
                        n_idx   = 4'd0;
                        n_phase = (r_remain == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid = 1'b1;
                    n_remain    = r_remain - 64'd1;
                    n_kidx      = r_kidx + 2'd1;
                    if (r_remain == 64'd1) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_fin    = |(i_byte & wsd_pkg::FIN_BIT);
                    n_opcode = 4'(i_byte & wsd_pkg::OPCODE_MASK);
                    n_masked = 1'b0;
                    n_key    = 32'd0;
                    n_remain = 64'd0;
                    n_idx    = 4'd0;
                    n_kidx   = 2'd0;
                    n_phase  = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_idx   <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
        r_opcode <= n_opcode;
        r_fin    <= n_fin;
        r_masked <= n_masked;
        r_remain <= n_remain;
        r_key    <= n_key;
        r_kidx   <= n_kidx;
    end

endmodule

### rtl/core/wsd_out_skid.sv
// ----------------------------------------------------------------------------
// wsd_out_skid
// Result register with a skid stage; input side stays open while one
// result waits.
// ----------------------------------------------------------------------------
module wsd_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsd_pkg::t_result i_res,
    output logic             o_space,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output wsd_pkg::t_result o_res
);

    logic             r_valid;
    logic             r_skid_valid;
    wsd_pkg::t_result r_res;
    wsd_pkg::t_result r_skid;
    logic             w_pop;

    assign w_pop   = r_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_full  = r_skid_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_pop && r_skid_valid) begin
                r_res        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (i_push && (!r_valid || w_pop)) begin
                r_res   <= i_res;
                r_valid <= 1'b1;
            end else if (i_push) begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end else if (w_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Frame header parser and payload unmasker for a post-handshake byte stream.
// ----------------------------------------------------------------------------
// Input channel: i_stream_byte with i_valid / o_ready, one stream byte per
// transfer. Header bytes, extended length and mask key produce nothing;
// each payload byte produces one output transfer on o_valid / i_ready with
// the unmasked byte, a last-of-frame flag, and the frame's opcode and FIN.
// Zero-length frames produce no output.
// Each payload byte is unmasked combinationally and registered in the result
// register (or the skid entry). Throughput: one byte per cycle unless output
// stalls, set by the combinational parse step and the result register.
// The result register has a one-entry skid stage: o_ready stays high while
// one result waits, and drops only once both entries are occupied.
// Reset (synchronous, active low) returns the parser to the first header
// byte and empties both output entries.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_stream_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_last_of_frame,
    output logic [3:0] o_frame_opcode,
    output logic       o_final_fragment
);

    logic             w_accept;
    logic             w_space;
    logic             w_full;
    logic             w_res_valid;
    wsd_pkg::t_result w_res;
    wsd_pkg::t_result w_out;

    assign o_ready  = w_space;
    assign w_accept = i_valid && w_space;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_stream_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wsd_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_space (w_space),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (w_out)
    );

    assign o_payload_byte   = w_out.payload_byte;
    assign o_last_of_frame  = w_out.last_of_frame;
    assign o_frame_opcode   = w_out.frame_opcode;
    assign o_final_fragment = w_out.final_fragment;

`ifndef SYNTH
    a_skid_implies_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> o_valid)
        else $error("skid entry held without a valid output entry");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && w_full))
        else $error("input stalled while output storage has room");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("output not empty after reset");
`endif

endmodule

### dv/websocket_frame_deframer_test.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_test
// Self-checking bench for the frame deframer: header parsing and unmasking.
// ----------------------------------------------------------------------------
// Frames are built as byte streams: every length form, masked and unmasked,
// zero-length frames, odd header bits and a huge 64-bit length. Each input
// transfer is run through a local deframer model, and every output transfer
// is checked field by field against the oldest predicted payload byte.
// Both sides idle in random bursts only during the first random-frame run.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PARSE_HDR0,
        PARSE_LEN,
        PARSE_EXT16,
        PARSE_EXT64,
        PARSE_KEY,
        PARSE_DATA
    } t_parse_phase;

    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } t_len_form;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_stream_byte = 8'h00;
    logic       i_ready = 1'b1;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_payload_byte;
    logic       o_last_of_frame;
    logic [3:0] o_frame_opcode;
    logic       o_final_fragment;

    // deframer model state
    t_parse_phase frame_phase = PARSE_HDR0;
    logic [3:0]   ext_index = '0;
    logic [3:0]   cur_opcode = '0;
    logic         cur_fin = 1'b0;
    logic         cur_masked = 1'b0;
    logic [63:0]  frame_len = '0;
    logic [31:0]  cur_key = '0;
    logic [63:0]  data_index = '0;

    wsd_pkg::t_result pending_payload[$];

    bit send_gaps_on = 1'b0;
    bit rx_stall_on = 1'b0;
    int stall_left = 0;
    int error_count = 0;
    int bytes_sent = 0;
    int frames_sent = 0;
    int results_checked = 0;

    websocket_frame_deframer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_stream_byte    (i_stream_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_payload_byte   (o_payload_byte),
        .o_last_of_frame  (o_last_of_frame),
        .o_frame_opcode   (o_frame_opcode),
        .o_final_fragment (o_final_fragment)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------- model ----------------
    task automatic start_payload();
        data_index = '0;
        frame_phase = (frame_len == 64'd0) ? PARSE_HDR0 : PARSE_DATA;
    endtask

    task automatic length_complete();
        ext_index = '0;
        if (cur_masked) begin
            frame_phase = PARSE_KEY;
        end else begin
            start_payload();
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        wsd_pkg::t_result r;
        logic             last;
        logic [7:0]       kb;
        case (frame_phase)
            PARSE_LEN: begin
                cur_masked = (b & wsd_pkg::MASK_BIT) != 8'h00;
                frame_len = {56'd0, b & wsd_pkg::LEN7_MASK};
                ext_index = '0;
                if (frame_len[6:0] == wsd_pkg::LEN_EXT16) begin
                    frame_len = '0;
                    frame_phase = PARSE_EXT16;
                end else if (frame_len[6:0] == wsd_pkg::LEN_EXT64) begin
                    frame_len = '0;
                    frame_phase = PARSE_EXT64;
                end else begin
                    length_complete();
                end
            end
            PARSE_EXT16, PARSE_EXT64: begin
                frame_len = {frame_len[55:0], b};
                ext_index = ext_index + 4'd1;
                if (ext_index >= ((frame_phase == PARSE_EXT16) ? wsd_pkg::EXT16_BYTES
                                                              : wsd_pkg::EXT64_BYTES)) begin
                    length_complete();
                end
            end
            PARSE_KEY: begin
                cur_key = {cur_key[23:0], b};
                ext_index = ext_index + 4'd1;
                if (ext_index >= wsd_pkg::KEY_BYTES) begin
                    ext_index = '0;
                    start_payload();
                end
            end
            PARSE_DATA: begin
                kb = cur_key[8 * (3 - data_index[1:0]) +: 8];
                last = (data_index + 64'd1 == frame_len);
                r.payload_byte = b ^ kb;
                r.last_of_frame = last;
                r.frame_opcode = cur_opcode;
                r.final_fragment = cur_fin;
                pending_payload = {pending_payload, r};
                data_index = data_index + 64'd1;
                if (last) begin
                    frame_phase = PARSE_HDR0;
                    data_index = '0;
                end
            end
            default: begin
                cur_fin = (b & wsd_pkg::FIN_BIT) != 8'h00;
                cur_opcode = b[3:0] & wsd_pkg::OPCODE_MASK[3:0];
                cur_masked = 1'b0;
                cur_key = '0;
                frame_len = '0;
                data_index = '0;
                ext_index = '0;
                frame_phase = PARSE_LEN;
            end
        endcase
    endtask

    // ---------------- monitor and checker ----------------
    always @(posedge i_clk) begin : monitor
        wsd_pkg::t_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                deframe_byte(i_stream_byte);
            end
            if (o_valid && i_ready) begin
                if (pending_payload.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("%0t: unexpected output: byte %02h last %0d op %0h fin %0d",
                                 $realtime, o_payload_byte, o_last_of_frame,
                                 o_frame_opcode, o_final_fragment);
                    end
                end else begin
                    want = pending_payload.pop_front();
                    results_checked++;
                    if (want.payload_byte !== o_payload_byte
                            || want.last_of_frame !== o_last_of_frame
                            || want.frame_opcode !== o_frame_opcode
                            || want.final_fragment !== o_final_fragment) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("%0t: mismatch: exp byte %02h last %0d op %0h fin %0d",
                                     $realtime, want.payload_byte, want.last_of_frame,
                                     want.frame_opcode, want.final_fragment);
                            $display("%0t:           got byte %02h last %0d op %0h fin %0d",
                                     $realtime, o_payload_byte, o_last_of_frame,
                                     o_frame_opcode, o_final_fragment);
                        end
                    end
                end
            end
        end
    end

    // output backpressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 13) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_byte(input logic [7:0] b);
        if (send_gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_stream_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic masked, input t_len_form form,
                              input logic [63:0] len, input logic [31:0] key,
                              input int n_data);
        send_byte(hdr);
        case (form)
            FORM_EXT16: begin
                send_byte({masked, wsd_pkg::LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            FORM_EXT64: begin
                send_byte({masked, wsd_pkg::LEN_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
            end
            default: send_byte({masked, len[6:0]});
        endcase
        if (masked) begin
            for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
        end
        for (int i = 0; i < n_data; i++) send_byte(8'($urandom_range(0, 255)));
        frames_sent++;
    endtask

    task automatic test_zero_length();
        send_frame(8'h00, 1'b0, FORM_SHORT, 64'd0, 32'h0, 0);
        send_frame(8'h8A, 1'b1, FORM_SHORT, 64'd0, 32'hDEADBEEF, 0);
    endtask

    task automatic test_masked_payload();
        // FIN, all RSV bits, opcode 0xF; key index wraps past four bytes
        send_frame(8'hFF, 1'b1, FORM_SHORT, 64'd5, 32'h0180FF7E, 5);
    endtask

    task automatic test_unmasked_after_masked();
        // non-minimal 16-bit length; key must not carry over
        send_frame(8'h82, 1'b0, FORM_EXT16, 64'd2, 32'h0, 2);
        send_frame(8'h70, 1'b1, FORM_EXT16, 64'd0, 32'h12345678, 0);
    endtask

    task automatic test_ext64_length();
        send_frame(8'h09, 1'b1, FORM_EXT64, 64'd1, 32'hFFFFFFFF, 1);
    endtask

    task automatic test_random_frames(input int byte_goal, input bit with_idle);
        int          pick;
        logic [63:0] len;
        t_len_form   form;
        int          goal;
        goal = bytes_sent + byte_goal;
        while (bytes_sent < goal) begin
            send_gaps_on = with_idle && ($urandom_range(0, 3) != 0);
            rx_stall_on = with_idle && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                form = FORM_SHORT;
                len = 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 125)
                                                       : $urandom_range(0, 12));
                if ($urandom_range(0, 19) == 0) len = 64'd125;
            end else if (pick < 9) begin
                form = FORM_EXT16;
                len = 64'(($urandom_range(0, 7) == 0) ? $urandom_range(126, 300)
                                                       : $urandom_range(0, 20));
            end else begin
                form = FORM_EXT64;
                len = 64'($urandom_range(0, 20));
            end
            send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, len,
                       $urandom, int'(len));
        end
        send_gaps_on = 1'b0;
        rx_stall_on = 1'b0;
    endtask

    task automatic test_top_bit_length();
        // frame never completes within the run; only its first bytes are sent
        send_frame(8'h81, 1'b1, FORM_EXT64, 64'h8000_0000_0000_0010, $urandom, 12);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length();
        test_masked_payload();
        test_unmasked_after_masked();
        test_ext64_length();
        test_random_frames(900, 1'b1);
        test_random_frames(150, 1'b0);
        test_top_bit_length();

        i_valid <= 1'b0;
        while (pending_payload.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Sent %0d stream bytes in %0d frames; checked %0d payload bytes.",
                 bytes_sent, frames_sent, results_checked);
        $display("Mismatches: %0d, leftover expectations: %0d.",
                 error_count, pending_payload.size());
        if (error_count == 0 && pending_payload.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### websocket_frame_deframer.f
rtl/core/wsd_pkg.sv
rtl/core/wsd_parser.sv
rtl/core/wsd_out_skid.sv
rtl/core/websocket_frame_deframer.sv
dv/websocket_frame_deframer_test.sv
